[rtl/rlfe_pkg.sv]
`default_nettype none

package rlfe_pkg;

	// Fixed-point and interval configuration.
	localparam int FRAC_BITS     = 16;
	localparam int INTERVAL_BITS = 16;
	localparam int NCH           = 4;

	// Derived widths: level is 8.FRAC_BITS unsigned, step is one bit wider and signed.
	localparam int LVL_W     = 8 + FRAC_BITS;
	localparam int STEP_W    = LVL_W + 1;
	localparam int SUM_W     = LVL_W + 2;
	localparam int IVAL_PORT = 16;
	localparam int IVAL_USED = (INTERVAL_BITS < IVAL_PORT) ? INTERVAL_BITS : IVAL_PORT;

	// The divider produces one quotient bit per cycle.
	localparam int DIV_STEPS = LVL_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [LVL_W-1:0] LEVEL_MAX = {8'hFF, {FRAC_BITS{1'b0}}};

	typedef logic [LVL_W-1:0]         level_t;
	typedef logic signed [STEP_W-1:0] step_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [INTERVAL_BITS-1:0] ival_t;

	// Command codes.
	typedef enum logic [2:0] {
		KIND_SET  = 3'd0,
		KIND_FADE = 3'd1,
		KIND_ADD  = 3'd2,
		KIND_OFF  = 3'd3,
		KIND_TICK = 3'd4
	} kind_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH
	} state_t;

	// Broadcast from the sequencer to every lane.
	typedef struct packed {
		logic       start;
		logic [2:0] kind;
		ival_t      ival;
		logic       div_step;
		logic       div_last;
	} lane_ctl_t;

	// What each lane reports to the merging stage.
	typedef struct packed {
		logic [7:0] level;
		logic       fading;
	} lane_stat_t;

	// Saturate a widened level sum to the range 0 .. 255.0.
	function automatic level_t clamp_level(input sum_t v);
		level_t r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, LEVEL_MAX})) begin
			r = LEVEL_MAX;
		end else begin
			r = v[LVL_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/rgbw_linear_fade_engine.sv]
// Four-channel (red, green, blue, white) fade engine with 8.16 fixed-point levels.
// Commands arrive on the cmd channel (cmd_valid / cmd_stall) with kind, four signed
// values and an interval; results leave on the res channel (res_valid / res_stall)
// with the four integer levels and the combined fading flag. Every command gives
// exactly one result, and codes 5 to 7 change nothing and only report.
// The four channels are processed by parallel lanes in the same cycle; each lane
// has its own restoring divider that yields one quotient bit per cycle.
// Sequence: a command transfer moves the sequencer to the result step, or for a
// fade_to with a nonzero interval first through the divider iterations; the result
// step loads the output register, which then raises res_valid.
// One command is in progress at a time, so a new command is accepted only after
// the result of the last one has been loaded into the output register.
// cmd_stall is high while a command is in progress. When the receiver holds res_stall,
// the result stays in its output register and the next command waits before its
// result is loaded.
// Reset (arst_n low) clears all levels, targets, steps and flags and empties the
// output register.
`default_nettype none

module rgbw_linear_fade_engine
	import rlfe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire logic [2:0]        kind,
	input  wire logic signed [8:0] red_value,
	input  wire logic signed [8:0] green_value,
	input  wire logic signed [8:0] blue_value,
	input  wire logic signed [8:0] white_value,
	input  wire logic [15:0]       interval,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [7:0]             red_level,
	output logic [7:0]             green_level,
	output logic [7:0]             blue_level,
	output logic [7:0]             white_level,
	output logic                   fading
);

	state_t     state_q;
	state_t     state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic       cmd_fire;
	logic       is_div;
	ival_t      ival;
	lane_ctl_t  ctl;
	logic       push;
	logic       can_load;

	logic signed [8:0] lane_value [NCH];
	lane_stat_t        lane_stat [NCH];
	logic [7:0]        levels [NCH];

	assign ival     = INTERVAL_BITS'(interval[IVAL_USED-1:0]);
	assign cmd_fire = cmd_valid && !cmd_stall;
	assign is_div   = (kind == KIND_FADE) && (ival != '0);

	// Next-state logic of the command sequencer.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					state_nx = is_div ? ST_DIV : ST_PUSH;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_nx = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (can_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd_stall    = (state_q != ST_IDLE);
		ctl.start    = cmd_fire;
		ctl.kind     = kind;
		ctl.ival     = ival;
		ctl.div_step = (state_q == ST_DIV);
		ctl.div_last = (state_q == ST_DIV) && (cnt_q == CNT_W'(DIV_STEPS - 1));
		push         = (state_q == ST_PUSH) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd_fire) begin
				cnt_q <= '0;
			end else if (ctl.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Channel lanes.
	assign lane_value[0] = red_value;
	assign lane_value[1] = green_value;
	assign lane_value[2] = blue_value;
	assign lane_value[3] = white_value;

	for (genvar g = 0; g < NCH; g++) begin : g_lane
		rlfe_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.value  (lane_value[g]),
			.stat   (lane_stat[g])
		);
	end

	// Merge the lanes into the result register.
	rlfe_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (push),
		.stat      (lane_stat),
		.res_stall (res_stall),
		.can_load  (can_load),
		.res_valid (res_valid),
		.levels    (levels),
		.fading    (fading)
	);

	assign red_level   = levels[0];
	assign green_level = levels[1];
	assign blue_level  = levels[2];
	assign white_level = levels[3];

	// A command that needs no division reaches the result step in the next cycle.
	a_fast_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && !is_div) |=> (state_q == ST_PUSH))
		else $error("command without division did not move to the result step");

	// A fade with a nonzero interval starts the divider from its first iteration.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && is_div) |=> (state_q == ST_DIV && cnt_q == '0))
		else $error("division did not start at iteration zero");

	// A loaded result shows up as valid in the next cycle.
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> res_valid)
		else $error("result load did not raise res_valid");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !push)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[rtl/rlfe_lane.sv]
`default_nettype none

module rlfe_lane
	import rlfe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lane_ctl_t         ctl,
	input  wire logic signed [8:0] value,
	output lane_stat_t             stat
);

	level_t     level_q;
	logic [7:0] target_q;
	step_t      step_q;
	logic       fading_q;

	// Divider working registers.
	ival_t      rem_q;
	level_t     quo_q;
	ival_t      div_q;
	logic       neg_q;

	logic [7:0]         t_byte;
	level_t             tf_new;
	level_t             tf_cur;
	logic signed [LVL_W:0] diff_new;
	logic signed [LVL_W:0] diff_cur;
	level_t             mag_new;
	level_t             mag_cur;
	step_t              step_mag;
	logic               snap;
	sum_t               sum_step;
	sum_t               sum_add;
	logic [INTERVAL_BITS:0] r_sh;
	logic               ge;
	ival_t              rem_nx;
	level_t             quo_nx;
	step_t              quo_ext;

	// Target from the command value: negative values read as zero.
	assign t_byte = value[8] ? 8'd0 : value[7:0];
	assign tf_new = {t_byte, {FRAC_BITS{1'b0}}};
	assign tf_cur = {target_q, {FRAC_BITS{1'b0}}};

	// Distances to the new and to the current target.
	assign diff_new = $signed({1'b0, tf_new}) - $signed({1'b0, level_q});
	assign diff_cur = $signed({1'b0, tf_cur}) - $signed({1'b0, level_q});
	assign mag_new  = diff_new[LVL_W] ? LVL_W'(-diff_new) : diff_new[LVL_W-1:0];
	assign mag_cur  = diff_cur[LVL_W] ? LVL_W'(-diff_cur) : diff_cur[LVL_W-1:0];
	assign step_mag = step_q[STEP_W-1] ? -step_q : step_q;

	// A tick snaps when the step is zero or would overshoot the target.
	assign snap = (step_q == '0) || ($unsigned({1'b0, mag_cur}) < $unsigned(step_mag));

	// Widened sums for a tick step and for an add delta.
	assign sum_step = $signed({2'b00, level_q}) + $signed({step_q[STEP_W-1], step_q});
	assign sum_add  = $signed({2'b00, level_q})
		+ $signed({value[8], value, {FRAC_BITS{1'b0}}});

	// One restoring division step.
	assign r_sh    = {rem_q, quo_q[LVL_W-1]};
	assign ge      = r_sh >= {1'b0, div_q};
	assign rem_nx  = ge ? INTERVAL_BITS'(r_sh - {1'b0, div_q}) : r_sh[INTERVAL_BITS-1:0];
	assign quo_nx  = {quo_q[LVL_W-2:0], ge};
	assign quo_ext = $signed({1'b0, quo_nx});

	// Channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			target_q <= '0;
			step_q   <= '0;
			fading_q <= 1'b0;
		end else if (ctl.start) begin
			case (ctl.kind)
				KIND_SET: begin
					target_q <= t_byte;
					level_q  <= tf_new;
					fading_q <= 1'b0;
				end
				KIND_FADE: begin
					target_q <= t_byte;
					if (ctl.ival == '0) begin
						level_q  <= tf_new;
						step_q   <= '0;
						fading_q <= 1'b0;
					end else begin
						fading_q <= (diff_new != '0);
					end
				end
				KIND_ADD: begin
					level_q <= clamp_level(sum_add);
				end
				KIND_OFF: begin
					level_q <= '0;
				end
				KIND_TICK: begin
					if (fading_q) begin
						if (snap) begin
							level_q  <= tf_cur;
							fading_q <= 1'b0;
						end else begin
							level_q <= clamp_level(sum_step);
						end
					end
				end
				default: begin
				end
			endcase
		end else if (ctl.div_last) begin
			step_q <= neg_q ? -quo_ext : quo_ext;
		end
	end

	// Divider datapath: loaded at every command start, then shifted once per cycle while dividing.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= mag_new;
			rem_q <= '0;
			div_q <= ctl.ival;
			neg_q <= diff_new[LVL_W];
		end else if (ctl.div_step) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign stat.level  = level_q[LVL_W-1:FRAC_BITS];
	assign stat.fading = fading_q;

endmodule

`default_nettype wire

[rtl/rlfe_merge.sv]
`default_nettype none

module rlfe_merge
	import rlfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire lane_stat_t stat [NCH],
	input  wire logic       res_stall,
	output logic            can_load,
	output logic            res_valid,
	output logic [7:0]      levels [NCH],
	output logic            fading
);

	logic       res_valid_q;
	logic [7:0] levels_q [NCH];
	logic       fading_q;
	logic       any_fading;

	// The register takes a new result when empty or when its transfer completes.
	assign can_load = !res_valid_q || !res_stall;

	// Combine the lane flags.
	always_comb begin
		any_fading = 1'b0;
		for (int i = 0; i < NCH; i++) begin
			any_fading = any_fading | stat[i].fading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NCH; i++) begin
				levels_q[i] <= stat[i].level;
			end
			fading_q <= any_fading;
		end
	end

	assign res_valid = res_valid_q;
	assign levels    = levels_q;
	assign fading    = fading_q;

endmodule

`default_nettype wire
